@@ rtl/lru_page_table_unit_defines.svh @@
// Assertion macros shared by the LRU page table RTL.
`ifndef LRU_PAGE_TABLE_UNIT_DEFINES_SVH
`define LRU_PAGE_TABLE_UNIT_DEFINES_SVH

// Checks a property at every clock edge outside reset.
`define LPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property at every clock edge, reset included.
`define LPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/lpt_pkg.sv @@
// Types and constants of the LRU page table.
`timescale 1ns / 1ps
`default_nettype none

package lpt_pkg;

  // Default sizing.
  localparam int CAPACITY    = 64;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 32;

  // Capacity register.
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // Request and status field widths.
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND         = 3'd0,
    REQ_FETCH        = 3'd1,
    REQ_TOUCH        = 3'd2,
    REQ_EVICT_KEY    = 3'd3,
    REQ_EVICT_LRU    = 3'd4,
    REQ_INSERT       = 3'd5,
    REQ_EVICT_INSERT = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_ABSENT    = 3'd1,
    STS_DUPLICATE = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  // Command for one cell of the chain; each cell gets its own.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_DN,
    CELL_SHIFT_UP,
    CELL_CLEAR,
    CELL_SET_HANDLE
  } cell_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

`default_nettype wire

@@ rtl/lpt_cell.sv @@
// One entry of the recency-ordered chain: key, handle and valid bit.
`timescale 1ns / 1ps
`default_nettype none

module lpt_cell #(
  parameter int KEY_BITS    = lpt_pkg::KEY_BITS,
  parameter int HANDLE_BITS = lpt_pkg::HANDLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lpt_pkg::cell_cmd_e     cmd_i,
  input  wire logic [KEY_BITS-1:0]    cmp_key_i,
  input  wire logic                   prev_valid_i,
  input  wire logic [KEY_BITS-1:0]    prev_key_i,
  input  wire logic [HANDLE_BITS-1:0] prev_handle_i,
  input  wire logic                   next_valid_i,
  input  wire logic [KEY_BITS-1:0]    next_key_i,
  input  wire logic [HANDLE_BITS-1:0] next_handle_i,
  input  wire logic [HANDLE_BITS-1:0] new_handle_i,
  output logic                        valid_o,
  output logic [KEY_BITS-1:0]         key_o,
  output logic [HANDLE_BITS-1:0]      handle_o,
  output logic                        hit_o
);

  logic                   valid_q, valid_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;

  // Next contents: more recent or older neighbor, cleared valid, new handle, or hold.
  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    handle_d = handle_q;
    case (cmd_i)
      lpt_pkg::CELL_SHIFT_DN: begin
        valid_d  = prev_valid_i;
        key_d    = prev_key_i;
        handle_d = prev_handle_i;
      end
      lpt_pkg::CELL_SHIFT_UP: begin
        valid_d  = next_valid_i;
        key_d    = next_key_i;
        handle_d = next_handle_i;
      end
      lpt_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      lpt_pkg::CELL_SET_HANDLE: begin
        handle_d = new_handle_i;
      end
      default: begin
      end
    endcase
  end

  // The valid bit is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset; it is read only while valid.
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign valid_o  = valid_q;
  assign key_o    = key_q;
  assign handle_o = handle_q;
  assign hit_o    = valid_q && (key_q == cmp_key_i);

endmodule

`default_nettype wire

@@ rtl/lru_page_table_unit.sv @@
// Top level of the LRU page table: request control and the chain of entry cells.
//
//  Channel  Signals                                         Direction
//  -------  ----------------------------------------------  ---------
//  in       in_valid_i/in_ready_o, req_type_i, page_key_i,   input
//           frame_handle_i
//  out      out_valid_o/out_ready_i, status_o, result_handle_o, output
//           evicted_valid_o, evicted_key_o, evicted_handle_o, occupancy_o
//  cfg      cfg_we_i, cfg_wdata_i (active capacity)          input
//
// The accept edge registers the parallel key compare of all cells, and the
// execute step, taken once the output register is free, applies the update to
// the chain and loads the output register. One transaction is in flight at a
// time. Entries sit in the chain in recency order, cell 0 most recent; a
// reorder is a shift of the cells between the front and the hit position.
// A result not taken holds the block in the execute step until out_ready_i.
// Reset empties the table at once; the capacity register resets to 64.
`timescale 1ns / 1ps
`default_nettype none

`include "lru_page_table_unit_defines.svh"

module lru_page_table_unit #(
  parameter int CAPACITY    = lpt_pkg::CAPACITY,
  parameter int KEY_BITS    = lpt_pkg::KEY_BITS,
  parameter int HANDLE_BITS = lpt_pkg::HANDLE_BITS,
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [lpt_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Requests
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [lpt_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [KEY_BITS-1:0]           page_key_i,
  input  wire logic [HANDLE_BITS-1:0]        frame_handle_i,
  // Results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lpt_pkg::STATUS_W-1:0]       status_o,
  output logic [HANDLE_BITS-1:0]             result_handle_o,
  output logic                               evicted_valid_o,
  output logic [KEY_BITS-1:0]                evicted_key_o,
  output logic [HANDLE_BITS-1:0]             evicted_handle_o,
  output logic [CNT_W-1:0]                   occupancy_o
);

  localparam int CMP_W = (CNT_W > lpt_pkg::CFG_W) ? CNT_W : lpt_pkg::CFG_W;
  localparam logic [CAPACITY-1:0] VEC_ONE = {{(CAPACITY-1){1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0]    CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

  // Control state.
  lpt_pkg::state_e             state_q, state_d;
  logic [lpt_pkg::CFG_W-1:0]   cap_q;
  logic [CNT_W-1:0]            count_q, count_n;
  logic [CAPACITY-1:0]         hit_q;

  // Latched request.
  logic [lpt_pkg::REQ_W-1:0]   req_q;
  logic [KEY_BITS-1:0]         key_q;
  logic [HANDLE_BITS-1:0]      handle_q;

  // Output register.
  logic                        out_valid_q;
  logic [lpt_pkg::STATUS_W-1:0] status_q;
  logic [HANDLE_BITS-1:0]      res_handle_q;
  logic                        ev_valid_q;
  logic [KEY_BITS-1:0]         ev_key_q;
  logic [HANDLE_BITS-1:0]      ev_handle_q;
  logic [CNT_W-1:0]            occ_q;

  // Chain signals.
  logic [CAPACITY-1:0]         cell_valid;
  logic [CAPACITY-1:0]         cell_hit;
  logic [KEY_BITS-1:0]         cell_key    [CAPACITY];
  logic [HANDLE_BITS-1:0]      cell_handle [CAPACITY];
  lpt_pkg::cell_cmd_e          cell_cmd    [CAPACITY];

  // Execute step.
  logic                        in_fire, exec_fire;
  logic [CNT_W-1:0]            eff_cap, cnt_after;
  logic                        hit_any, evict_lru;
  logic [KEY_BITS-1:0]         sel_key, old_key, front_key;
  logic [HANDLE_BITS-1:0]      sel_handle, old_handle, front_handle;
  logic [CAPACITY-1:0]         oldest_vec, below_hit, upto_hit, from_hit;
  logic [CAPACITY-1:0]         dn_mask, up_mask, clr_mask, upd_mask;
  lpt_pkg::status_e            status_n;
  logic [HANDLE_BITS-1:0]      res_n;
  logic                        ev_valid_n;
  logic [KEY_BITS-1:0]         ev_key_n;
  logic [HANDLE_BITS-1:0]      ev_handle_n;

  assign in_fire   = in_valid_i && in_ready_o;
  assign exec_fire = (state_q == lpt_pkg::ST_EXEC) && (!out_valid_q || out_ready_i);

  // Effective capacity saturates at the number of cells.
  assign eff_cap = (CMP_W'(cap_q) > CMP_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cap_q);

  // The least recent entry is the last valid cell of the packed chain.
  assign oldest_vec = cell_valid & ~{1'b0, cell_valid[CAPACITY-1:1]};

  // Read of the hit entry and of the least recent entry (both one-hot).
  always_comb begin
    sel_key    = '0;
    sel_handle = '0;
    old_key    = '0;
    old_handle = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key    = sel_key    | ({KEY_BITS{hit_q[i]}} & cell_key[i]);
      sel_handle = sel_handle | ({HANDLE_BITS{hit_q[i]}} & cell_handle[i]);
      old_key    = old_key    | ({KEY_BITS{oldest_vec[i]}} & cell_key[i]);
      old_handle = old_handle | ({HANDLE_BITS{oldest_vec[i]}} & cell_handle[i]);
    end
  end

  // Position masks around the hit cell.
  assign hit_any   = |hit_q;
  assign below_hit = hit_q - VEC_ONE;
  assign upto_hit  = below_hit | hit_q;
  assign from_hit  = ~below_hit;

  assign evict_lru = (count_q >= eff_cap) && (count_q != '0);
  assign cnt_after = count_q - (evict_lru ? CNT_ONE : '0);

  // Decode the request into chain moves and the result.
  always_comb begin
    dn_mask      = '0;
    up_mask      = '0;
    clr_mask     = '0;
    upd_mask     = '0;
    front_key    = key_q;
    front_handle = handle_q;
    status_n     = lpt_pkg::STS_OK;
    res_n        = '0;
    ev_valid_n   = 1'b0;
    ev_key_n     = '0;
    ev_handle_n  = '0;
    count_n      = count_q;
    case (lpt_pkg::req_e'(req_q))
      lpt_pkg::REQ_FIND: begin
        if (!hit_any) status_n = lpt_pkg::STS_ABSENT;
      end
      lpt_pkg::REQ_FETCH: begin
        if (!hit_any) begin
          status_n = lpt_pkg::STS_ABSENT;
        end else begin
          res_n        = sel_handle;
          dn_mask      = upto_hit;
          front_key    = sel_key;
          front_handle = sel_handle;
        end
      end
      lpt_pkg::REQ_TOUCH: begin
        if (!hit_any) begin
          status_n = lpt_pkg::STS_ABSENT;
        end else begin
          res_n = sel_handle;
        end
      end
      lpt_pkg::REQ_EVICT_KEY: begin
        if (!hit_any) begin
          status_n = lpt_pkg::STS_ABSENT;
        end else begin
          res_n   = sel_handle;
          up_mask = from_hit;
          count_n = count_q - CNT_ONE;
        end
      end
      lpt_pkg::REQ_EVICT_LRU: begin
        if (count_q == '0) begin
          status_n = lpt_pkg::STS_EMPTY;
        end else begin
          ev_valid_n  = 1'b1;
          ev_key_n    = old_key;
          ev_handle_n = old_handle;
          clr_mask    = oldest_vec;
          count_n     = count_q - CNT_ONE;
        end
      end
      lpt_pkg::REQ_INSERT: begin
        if (hit_any) begin
          status_n = lpt_pkg::STS_DUPLICATE;
        end else if (count_q >= eff_cap) begin
          status_n = lpt_pkg::STS_FULL;
        end else begin
          dn_mask = '1;
          count_n = count_q + CNT_ONE;
        end
      end
      lpt_pkg::REQ_EVICT_INSERT: begin
        if (hit_any) begin
          upd_mask = hit_q;
        end else begin
          if (evict_lru) begin
            ev_valid_n  = 1'b1;
            ev_key_n    = old_key;
            ev_handle_n = old_handle;
          end
          if (cnt_after >= eff_cap) begin
            // Still full after the eviction: the insertion is refused.
            status_n = lpt_pkg::STS_FULL;
            clr_mask = evict_lru ? oldest_vec : '0;
            count_n  = cnt_after;
          end else begin
            // The evicted entry is dropped where it lands after the shift.
            dn_mask  = '1;
            clr_mask = evict_lru ? (oldest_vec << 1) : '0;
            count_n  = cnt_after + CNT_ONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Chain of cells, cell 0 most recent.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   prev_valid, next_valid;
    logic [KEY_BITS-1:0]    prev_key, next_key;
    logic [HANDLE_BITS-1:0] prev_handle, next_handle;

    if (i == 0) begin : g_front
      assign prev_valid  = 1'b1;
      assign prev_key    = front_key;
      assign prev_handle = front_handle;
    end else begin : g_mid
      assign prev_valid  = cell_valid[i-1];
      assign prev_key    = cell_key[i-1];
      assign prev_handle = cell_handle[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign next_valid  = 1'b0;
      assign next_key    = '0;
      assign next_handle = '0;
    end else begin : g_inner
      assign next_valid  = cell_valid[i+1];
      assign next_key    = cell_key[i+1];
      assign next_handle = cell_handle[i+1];
    end

    // Clear wins over the other moves, so an entry shifted past the end drops.
    always_comb begin
      if (!exec_fire) begin
        cell_cmd[i] = lpt_pkg::CELL_HOLD;
      end else if (clr_mask[i]) begin
        cell_cmd[i] = lpt_pkg::CELL_CLEAR;
      end else if (upd_mask[i]) begin
        cell_cmd[i] = lpt_pkg::CELL_SET_HANDLE;
      end else if (up_mask[i]) begin
        cell_cmd[i] = lpt_pkg::CELL_SHIFT_UP;
      end else if (dn_mask[i]) begin
        cell_cmd[i] = lpt_pkg::CELL_SHIFT_DN;
      end else begin
        cell_cmd[i] = lpt_pkg::CELL_HOLD;
      end
    end

    lpt_cell #(
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cell_cmd[i]),
      .cmp_key_i     (page_key_i),
      .prev_valid_i  (prev_valid),
      .prev_key_i    (prev_key),
      .prev_handle_i (prev_handle),
      .next_valid_i  (next_valid),
      .next_key_i    (next_key),
      .next_handle_i (next_handle),
      .new_handle_i  (handle_q),
      .valid_o       (cell_valid[i]),
      .key_o         (cell_key[i]),
      .handle_o      (cell_handle[i]),
      .hit_o         (cell_hit[i])
    );
  end

  // Sequencer: accept, then execute once the output register is free.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      lpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = lpt_pkg::ST_EXEC;
      end
      lpt_pkg::ST_EXEC: begin
        if (exec_fire) state_d = lpt_pkg::ST_IDLE;
      end
      default: begin
        state_d = lpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpt_pkg::ST_IDLE;
      cap_q       <= lpt_pkg::CAP_RESET;
      count_q     <= '0;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (in_fire) hit_q <= cell_hit;
      if (exec_fire) begin
        count_q     <= count_n;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q    <= req_type_i;
      key_q    <= page_key_i;
      handle_q <= frame_handle_i;
    end
    if (exec_fire) begin
      status_q     <= status_n;
      res_handle_q <= res_n;
      ev_valid_q   <= ev_valid_n;
      ev_key_q     <= ev_key_n;
      ev_handle_q  <= ev_handle_n;
      occ_q        <= count_n;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign result_handle_o  = res_handle_q;
  assign evicted_valid_o  = ev_valid_q;
  assign evicted_key_o    = ev_key_q;
  assign evicted_handle_o = ev_handle_q;
  assign occupancy_o      = occ_q;

  // Consistency of the chain and the entry count.
  `LPT_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `LPT_ASSERT(a_count_matches, $countones(cell_valid) == count_q, "count differs from valid cells")
  `LPT_ASSERT(a_valid_packed, (cell_valid & (cell_valid + VEC_ONE)) == '0, "valid cells not packed at front")
  `LPT_ASSERT(a_hit_unique, $onehot0(hit_q), "key matched in more than one cell")

endmodule

`default_nettype wire

@@ verif/lru_page_table_unit_tb.sv @@
// Self-checking testbench for the LRU page table with a built-in table predictor.
`timescale 1ns / 1ps

module lru_page_table_unit_tb;

  localparam int CAPACITY    = lpt_pkg::CAPACITY;
  localparam int KEY_BITS    = lpt_pkg::KEY_BITS;
  localparam int HANDLE_BITS = lpt_pkg::HANDLE_BITS;
  localparam int CFG_W       = lpt_pkg::CFG_W;
  localparam int REQ_W       = lpt_pkg::REQ_W;
  localparam int STATUS_W    = lpt_pkg::STATUS_W;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int POOL_SIZE = 96;
  localparam int SEGMENT_ITEMS = 240;

  // Expected outcome of one request.
  typedef struct {
    lpt_pkg::status_e        status;
    logic [HANDLE_BITS-1:0]  handle;
    logic                    ev_valid;
    logic [KEY_BITS-1:0]     ev_key;
    logic [HANDLE_BITS-1:0]  ev_handle;
    logic [OCC_W-1:0]        occupancy;
  } table_reply_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [REQ_W-1:0]        req_type_i = '0;
  logic [KEY_BITS-1:0]     page_key_i = '0;
  logic [HANDLE_BITS-1:0]  frame_handle_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [STATUS_W-1:0]     status_o;
  logic [HANDLE_BITS-1:0]  result_handle_o;
  logic                    evicted_valid_o;
  logic [KEY_BITS-1:0]     evicted_key_o;
  logic [HANDLE_BITS-1:0]  evicted_handle_o;
  logic [OCC_W-1:0]        occupancy_o;

  // Shadow copy of the table contents and the capacity register.
  logic [KEY_BITS-1:0]     tbl_key [CAPACITY];
  logic [HANDLE_BITS-1:0]  tbl_handle [CAPACITY];
  bit                      tbl_valid [CAPACITY];
  int unsigned             tbl_rank [CAPACITY];
  int unsigned             tbl_count = 0;
  logic [CFG_W-1:0]        tbl_cap = lpt_pkg::CAP_RESET;

  table_reply_t            pending_replies [$];
  logic [KEY_BITS-1:0]     key_pool [POOL_SIZE];
  int unsigned             send_idle_pct = 0;
  int unsigned             recv_stall_pct = 0;
  int unsigned             mismatches = 0;

  lru_page_table_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .page_key_i       (page_key_i),
    .frame_handle_i   (frame_handle_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .result_handle_o  (result_handle_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_key_o    (evicted_key_o),
    .evicted_handle_o (evicted_handle_o),
    .occupancy_o      (occupancy_o)
  );

  always #6 clk_i = ~clk_i;

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Slot holding the least recent entry, or -1 when the table is empty.
  function automatic int oldest_slot();
    for (int i = 0; i < CAPACITY; i++) begin
      if (tbl_valid[i] && tbl_rank[i] + 1 == tbl_count) return i;
    end
    return -1;
  endfunction

  // Removes an entry and closes the gap it leaves in the recency order.
  function automatic void drop_slot(int s);
    int unsigned r;
    r = tbl_rank[s];
    for (int i = 0; i < CAPACITY; i++) begin
      if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
    end
    tbl_valid[s] = 1'b0;
    tbl_rank[s] = 0;
    if (tbl_count > 0) tbl_count--;
  endfunction

  // Places a new entry in the lowest free slot as the most recent one.
  function automatic bit add_entry(logic [KEY_BITS-1:0] key,
                                   logic [HANDLE_BITS-1:0] handle);
    int s;
    s = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!tbl_valid[i]) begin
        s = i;
        break;
      end
    end
    if (s < 0) return 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tbl_valid[i]) tbl_rank[i]++;
    end
    tbl_valid[s] = 1'b1;
    tbl_key[s] = key;
    tbl_handle[s] = handle;
    tbl_rank[s] = 0;
    tbl_count++;
    return 1'b1;
  endfunction

  // Applies one request to the shadow table and returns the reply it should give.
  function automatic table_reply_t apply_request(lpt_pkg::req_e req,
                                                 logic [KEY_BITS-1:0] key,
                                                 logic [HANDLE_BITS-1:0] handle);
    table_reply_t r;
    int           hit;
    int           old;
    int unsigned  cap;
    int unsigned  hit_rank;
    r.status = lpt_pkg::STS_OK;
    r.handle = '0;
    r.ev_valid = 1'b0;
    r.ev_key = '0;
    r.ev_handle = '0;
    cap = (tbl_cap > CAPACITY) ? CAPACITY : tbl_cap;
    hit = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) begin
        hit = i;
        break;
      end
    end
    case (req)
      lpt_pkg::REQ_FIND: begin
        if (hit < 0) r.status = lpt_pkg::STS_ABSENT;
      end
      lpt_pkg::REQ_FETCH, lpt_pkg::REQ_TOUCH: begin
        if (hit < 0) begin
          r.status = lpt_pkg::STS_ABSENT;
        end else begin
          r.handle = tbl_handle[hit];
          // A fetch moves the entry to the front; a touch leaves the order alone.
          if (req == lpt_pkg::REQ_FETCH) begin
            hit_rank = tbl_rank[hit];
            for (int i = 0; i < CAPACITY; i++) begin
              if (tbl_valid[i] && tbl_rank[i] < hit_rank) tbl_rank[i]++;
            end
            tbl_rank[hit] = 0;
          end
        end
      end
      lpt_pkg::REQ_EVICT_KEY: begin
        if (hit < 0) begin
          r.status = lpt_pkg::STS_ABSENT;
        end else begin
          r.handle = tbl_handle[hit];
          drop_slot(hit);
        end
      end
      lpt_pkg::REQ_EVICT_LRU: begin
        old = oldest_slot();
        if (tbl_count == 0 || old < 0) begin
          r.status = lpt_pkg::STS_EMPTY;
        end else begin
          r.ev_valid = 1'b1;
          r.ev_key = tbl_key[old];
          r.ev_handle = tbl_handle[old];
          drop_slot(old);
        end
      end
      lpt_pkg::REQ_INSERT: begin
        if (hit >= 0) r.status = lpt_pkg::STS_DUPLICATE;
        else if (tbl_count >= cap || !add_entry(key, handle)) r.status = lpt_pkg::STS_FULL;
      end
      lpt_pkg::REQ_EVICT_INSERT: begin
        if (hit >= 0) begin
          // A present key only gets its handle replaced.
          tbl_handle[hit] = handle;
        end else begin
          if (tbl_count >= cap && tbl_count > 0) begin
            old = oldest_slot();
            if (old >= 0) begin
              r.ev_valid = 1'b1;
              r.ev_key = tbl_key[old];
              r.ev_handle = tbl_handle[old];
              drop_slot(old);
            end
          end
          if (tbl_count >= cap || !add_entry(key, handle)) r.status = lpt_pkg::STS_FULL;
        end
      end
      default: ;
    endcase
    r.occupancy = tbl_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Each result transaction is checked against the oldest outstanding reply.
  always @(posedge clk_i) begin
    table_reply_t exp_reply;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatches++;
      end else begin
        exp_reply = pending_replies.pop_front();
        check_field("status", exp_reply.status, status_o);
        check_field("result_handle", exp_reply.handle, result_handle_o);
        check_field("evicted_valid", exp_reply.ev_valid, evicted_valid_o);
        check_field("evicted_key", exp_reply.ev_key, evicted_key_o);
        check_field("evicted_handle", exp_reply.ev_handle, evicted_handle_o);
        check_field("occupancy", exp_reply.occupancy, occupancy_o);
      end
    end
  end

  // Sends one request transaction, with an optional idle gap ahead of it.
  task automatic send_request(lpt_pkg::req_e req, logic [KEY_BITS-1:0] key,
                              logic [HANDLE_BITS-1:0] handle);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    page_key_i <= key;
    frame_handle_i <= handle;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_replies.push_back(apply_request(req, key, handle));
  endtask

  // Drains all outstanding replies, then writes the capacity register.
  task automatic set_capacity(logic [CFG_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tbl_cap = cap;
  endtask

  function automatic lpt_pkg::req_e random_request();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return lpt_pkg::REQ_FIND;
    if (roll < 25) return lpt_pkg::REQ_FETCH;
    if (roll < 35) return lpt_pkg::REQ_TOUCH;
    if (roll < 45) return lpt_pkg::REQ_EVICT_KEY;
    if (roll < 53) return lpt_pkg::REQ_EVICT_LRU;
    if (roll < 78) return lpt_pkg::REQ_INSERT;
    return lpt_pkg::REQ_EVICT_INSERT;
  endfunction

  // Most keys come from a small pool so that hits, duplicates and a full table occur.
  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return $urandom;
  endfunction

  // Every request type but the two insertions against an empty table.
  task automatic test_empty_table();
    send_request(lpt_pkg::REQ_FIND, 32'h0000_0000, 32'h0000_0000);
    send_request(lpt_pkg::REQ_FETCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lpt_pkg::REQ_TOUCH, 32'h1234_5678, 32'h0000_0000);
    send_request(lpt_pkg::REQ_EVICT_KEY, 32'h0000_0000, 32'h0000_0000);
    send_request(lpt_pkg::REQ_EVICT_LRU, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Inserts, duplicates, lookups, an in-place update and both kinds of removal.
  task automatic test_insert_and_lookup();
    send_request(lpt_pkg::REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lpt_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lpt_pkg::REQ_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(lpt_pkg::REQ_INSERT, 32'h0000_0000, 32'h1111_1111);
    send_request(lpt_pkg::REQ_FIND, 32'h0000_0000, 32'h0000_0000);
    send_request(lpt_pkg::REQ_FETCH, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lpt_pkg::REQ_TOUCH, 32'h0000_0000, 32'h0000_0000);
    send_request(lpt_pkg::REQ_EVICT_INSERT, 32'h0000_0000, 32'hC0DE_CAFE);
    send_request(lpt_pkg::REQ_EVICT_KEY, 32'hAAAA_AAAA, 32'h0000_0000);
    send_request(lpt_pkg::REQ_EVICT_LRU, 32'h0000_0000, 32'h0000_0000);
  endtask

  // A full table, a capacity lowered below the count, and a capacity of zero.
  task automatic test_capacity_limits();
    set_capacity(7'd2);
    send_request(lpt_pkg::REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(lpt_pkg::REQ_INSERT, 32'h0F0F_0F0F, 32'h0000_0001);
    send_request(lpt_pkg::REQ_EVICT_INSERT, 32'hF0F0_F0F0, 32'h0000_0002);
    set_capacity(7'd1);
    send_request(lpt_pkg::REQ_INSERT, 32'h3333_3333, 32'h0000_0003);
    send_request(lpt_pkg::REQ_EVICT_INSERT, 32'h3333_3333, 32'h0000_0004);
    set_capacity(7'd0);
    send_request(lpt_pkg::REQ_INSERT, 32'h7777_7777, 32'h0000_0005);
    send_request(lpt_pkg::REQ_EVICT_INSERT, 32'h8888_8888, 32'h0000_0006);
    send_request(lpt_pkg::REQ_FIND, 32'h8888_8888, 32'h0000_0000);
  endtask

  // Random traffic over several capacities and idle patterns.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] caps [8];
    int unsigned      send_pct [4];
    int unsigned      recv_pct [4];
    caps = '{7'd64, 7'd127, 7'd3, 7'd1, 7'd17, 7'd0, 7'd64, 7'd33};
    send_pct = '{0, 82, 0, 17};
    recv_pct = '{0, 0, 82, 17};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int seg = 0; seg < 8; seg++) begin
      set_capacity(caps[seg]);
      send_idle_pct = send_pct[seg % 4];
      recv_stall_pct = recv_pct[seg % 4];
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        send_request(random_request(), pick_key(), pick_handle());
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    test_empty_table();
    test_insert_and_lookup();
    test_capacity_limits();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
